@@ rtl/uart_receiver_edge_resync_core_macros.svh @@
// assertion macros used by the receiver rtl
`ifndef UART_RECEIVER_EDGE_RESYNC_CORE_MACROS_SVH
`define UART_RECEIVER_EDGE_RESYNC_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define UARTRX_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication, checked outside reset
`define UARTRX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define UARTRX_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define UARTRX_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/uartrx_pkg.sv @@
package uartrx_pkg;

   localparam int DATA_BITS = 8;
   localparam int CNT_W     = 16;

   // receiver phases: idle, start, data bits lsb first, stop
   typedef enum logic [3:0] {
      PH_IDLE  = 4'd0,
      PH_START = 4'd1,
      PH_D0    = 4'd2,
      PH_D1    = 4'd3,
      PH_D2    = 4'd4,
      PH_D3    = 4'd5,
      PH_D4    = 4'd6,
      PH_D5    = 4'd7,
      PH_D6    = 4'd8,
      PH_D7    = 4'd9,
      PH_STOP  = 4'd10
   } phase_type;

   // beat kinds
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_LEVEL = 1'b1;

   // csr register indexes
   localparam logic [1:0] CSR_HALF_BIT     = 2'd0;
   localparam logic [1:0] CSR_ONE_BIT      = 2'd1;
   localparam logic [1:0] CSR_ONE_HALF_BIT = 2'd2;

   // csr reset values
   localparam logic [CNT_W-1:0] HALF_BIT_RST     = 16'd2;
   localparam logic [CNT_W-1:0] ONE_BIT_RST      = 16'd4;
   localparam logic [CNT_W-1:0] ONE_HALF_BIT_RST = 16'd6;

   typedef struct packed {
      phase_type                phase;
      logic [CNT_W-1:0]         countdown;
      logic                     last_level;
      logic [DATA_BITS-1:0]     shift_byte;
   } rx_state_type;

   typedef struct packed {
      logic [CNT_W-1:0] half_bit;
      logic [CNT_W-1:0] one_bit;
      logic [CNT_W-1:0] one_half_bit;
   } rx_cfg_type;

endpackage

@@ rtl/uart_receiver_edge_resync_core.sv @@
// 8N1 receiver fed by beats that are either a timer tick or a receive line
// level change. Each beat is a single state update: one beat is taken in
// every clock while req_ready is high, and a completed byte appears on the
// rsp channel in the cycle after the beat that ends the frame, held in a
// one-entry output register. req_ready drops only while that register holds
// a byte that rsp_ready has not taken. Timing registers are written through
// csr_we/csr_index/csr_wdata and take effect for the next beat.
`include "uart_receiver_edge_resync_core_macros.svh"
module uart_receiver_edge_resync_core
   import uartrx_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [1:0]           csr_index,
   input  logic [CNT_W-1:0]     csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_cmd,
   input  logic                 req_line_level,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_BITS-1:0] rsp_rx_byte
);

   rx_cfg_type           cfg_ff;
   rx_state_type         state_ff;
   rx_state_type         state_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_byte_ff;
   logic                 emit;
   logic [DATA_BITS-1:0] emit_byte;
   logic                 req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // timing registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_bit     <= HALF_BIT_RST;
         cfg_ff.one_bit      <= ONE_BIT_RST;
         cfg_ff.one_half_bit <= ONE_HALF_BIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_HALF_BIT:     cfg_ff.half_bit     <= csr_wdata;
            CSR_ONE_BIT:      cfg_ff.one_bit      <= csr_wdata;
            CSR_ONE_HALF_BIT: cfg_ff.one_half_bit <= csr_wdata;
            default: ;
         endcase
      end
   end

   uartrx_step u_step (
      .state      (state_ff),
      .cfg        (cfg_ff),
      .cmd        (req_cmd),
      .line_level (req_line_level),
      .state_next (state_in),
      .emit       (emit),
      .emit_byte  (emit_byte)
   );

   // receiver state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_IDLE;
         state_ff.countdown  <= '0;
         state_ff.last_level <= 1'b1;
         state_ff.shift_byte <= '0;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (req_fire && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && emit) begin
         rsp_byte_ff <= emit_byte;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_rx_byte = rsp_byte_ff;

   // checks
   `UARTRX_ASSERT_NOW(a_phase_range, clock, reset, 1'b1, state_ff.phase <= PH_STOP, "phase beyond stop")
   `UARTRX_ASSERT_NEXT(a_emit_shows, clock, reset, req_fire && emit, rsp_valid, "byte lost")
   `UARTRX_ASSERT_NEXT(a_idle_tick, clock, reset, req_fire && req_cmd == CMD_TICK && state_ff.phase == PH_IDLE, $stable(state_ff), "tick changed idle state")
   `UARTRX_ASSERT_NOW(a_stall_cause, clock, reset, !req_ready, rsp_valid_ff && !rsp_ready, "stall without pending byte")
   `UARTRX_ASSERT_NEXT(a_emit_idle, clock, reset, req_fire && emit, state_ff.phase == PH_IDLE, "frame end not idle")

endmodule

@@ rtl/uartrx_step.sv @@
module uartrx_step
   import uartrx_pkg::*;
(
   input  rx_state_type         state,
   input  rx_cfg_type           cfg,
   input  logic                 cmd,
   input  logic                 line_level,
   output rx_state_type         state_next,
   output logic                 emit,
   output logic [DATA_BITS-1:0] emit_byte
);

   logic [CNT_W-1:0]     cnt_dec;
   logic [DATA_BITS-1:0] shift_new;
   logic [DATA_BITS-1:0] shift_old_lvl;

   assign cnt_dec       = state.countdown - {{(CNT_W-1){1'b0}}, 1'b1};
   assign shift_new     = {line_level, state.shift_byte[DATA_BITS-1:1]};
   assign shift_old_lvl = {state.last_level, state.shift_byte[DATA_BITS-1:1]};

   // one beat of receiver state update
   always_comb begin
      state_next = state;
      emit       = 1'b0;
      emit_byte  = state.shift_byte;
      if (state.phase > PH_STOP) begin
         state_next.phase = PH_IDLE;
      end else if (cmd == CMD_LEVEL) begin
         // level change acts at once
         state_next.last_level = line_level;
         unique case (state.phase)
            PH_IDLE: begin
               if (!line_level) begin
                  state_next.countdown = cfg.half_bit;
                  state_next.phase     = PH_START;
               end
            end
            PH_STOP: begin
               if (line_level) begin
                  state_next.phase = PH_IDLE;
                  emit             = 1'b1;
               end else begin
                  // low in stop restarts the frame
                  state_next.countdown = cfg.half_bit;
                  state_next.phase     = PH_START;
               end
            end
            default: begin
               state_next.shift_byte = shift_new;
               if (state.phase == PH_D7) begin
                  // early stop
                  state_next.phase = PH_IDLE;
                  emit             = 1'b1;
                  emit_byte        = shift_new;
               end else begin
                  state_next.countdown = cfg.one_half_bit;
                  state_next.phase     = phase_type'(state.phase + 4'd1);
               end
            end
         endcase
      end else if (state.phase != PH_IDLE) begin
         // timer tick: count down, sample on expiry
         state_next.countdown = cnt_dec;
         if (cnt_dec == '0) begin
            unique case (state.phase)
               PH_START: begin
                  if (state.last_level) begin
                     state_next.phase = PH_IDLE;
                  end else begin
                     state_next.countdown = cfg.one_bit;
                     state_next.phase     = PH_D0;
                  end
               end
               PH_STOP: begin
                  state_next.phase = PH_IDLE;
                  emit             = state.last_level;
               end
               default: begin
                  state_next.shift_byte = shift_old_lvl;
                  state_next.countdown  = cfg.one_bit;
                  state_next.phase      = phase_type'(state.phase + 4'd1);
               end
            endcase
         end
      end
   end

endmodule

@@ bench/tb_uart_receiver_edge_resync_core.sv @@
`timescale 1ns / 1ps

module tb_uart_receiver_edge_resync_core;
   import uartrx_pkg::*;

   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic cmd;
      logic level;
   } line_event_type;

   // block ports
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_we = 1'b0;
   logic [1:0]           csr_index = CSR_HALF_BIT;
   logic [CNT_W-1:0]     csr_wdata = '0;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_cmd = CMD_TICK;
   logic                 req_line_level = 1'b1;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [DATA_BITS-1:0] rsp_rx_byte;

   // stimulus and scoreboard state
   line_event_type       line_events[$];
   logic [7:0]           rx_bytes_due[$];
   line_event_type       next_event;
   logic [7:0]           due_byte;
   logic                 req_taken = 1'b0;
   logic                 line_now = 1'b1;
   logic                 no_idle = 1'b0;
   int                   hold_ask = 0;
   int                   hold_served = 0;
   int                   hold_left = 0;
   int                   beats_queued = 0;
   int                   bytes_checked = 0;
   int                   mismatches = 0;
   int                   stall_cycles = 0;

   // receiver model state
   phase_type            rx_phase;
   logic [CNT_W-1:0]     rx_count;
   logic                 rx_level;
   logic [7:0]           rx_shift;
   rx_cfg_type           rx_cfg;

   uart_receiver_edge_resync_core dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_line_level (req_line_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rx_byte    (rsp_rx_byte)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver state update for one beat, queues the byte a frame delivers
   function automatic void receive_beat(input logic cmd, input logic lvl);
      if (rx_phase > PH_STOP) begin
         rx_phase = PH_IDLE;
      end else if (cmd == CMD_LEVEL) begin
         rx_level = lvl;
         if (rx_phase == PH_IDLE) begin
            if (!rx_level) begin
               rx_count = rx_cfg.half_bit;
               rx_phase = PH_START;
            end
         end else if (rx_phase == PH_STOP) begin
            // high ends the frame, low restarts reception
            if (rx_level) begin
               rx_phase = PH_IDLE;
               rx_bytes_due.push_back(rx_shift);
            end else begin
               rx_count = rx_cfg.half_bit;
               rx_phase = PH_START;
            end
         end else begin
            // edge shifts at once and resyncs the countdown
            rx_shift = {rx_level, rx_shift[7:1]};
            rx_phase = phase_type'(rx_phase + 4'd1);
            if (rx_phase == PH_STOP) begin
               rx_phase = PH_IDLE;
               rx_bytes_due.push_back(rx_shift);
            end else begin
               rx_count = rx_cfg.one_half_bit;
            end
         end
      end else if (rx_phase != PH_IDLE) begin
         rx_count = rx_count - 16'd1;
         if (rx_count == 16'd0) begin
            if (rx_phase == PH_START) begin
               if (rx_level) begin
                  rx_phase = PH_IDLE;
               end else begin
                  rx_count = rx_cfg.one_bit;
                  rx_phase = PH_D0;
               end
            end else if (rx_phase == PH_STOP) begin
               rx_phase = PH_IDLE;
               if (rx_level)
                  rx_bytes_due.push_back(rx_shift);
            end else begin
               rx_shift = {rx_level, rx_shift[7:1]};
               rx_count = rx_cfg.one_bit;
               rx_phase = phase_type'(rx_phase + 4'd1);
            end
         end
      end
   endfunction

   // monitor: check bytes, track timing registers, predict per accepted beat
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && req_ready;
      if (reset) begin
         rx_phase = PH_IDLE;
         rx_count = '0;
         rx_level = 1'b1;
         rx_shift = '0;
         rx_cfg = '{HALF_BIT_RST, ONE_BIT_RST, ONE_HALF_BIT_RST};
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rx_bytes_due.size() == 0) begin
               $display("%0t rx_byte unexpected: expected none actual %02h",
                        $time, rsp_rx_byte);
               mismatches++;
            end else begin
               due_byte = rx_bytes_due.pop_front();
               bytes_checked++;
               if (rsp_rx_byte !== due_byte) begin
                  $display("%0t rx_byte mismatch: expected %02h actual %02h",
                           $time, due_byte, rsp_rx_byte);
                  mismatches++;
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_HALF_BIT:     rx_cfg.half_bit = csr_wdata;
               CSR_ONE_BIT:      rx_cfg.one_bit = csr_wdata;
               CSR_ONE_HALF_BIT: rx_cfg.one_half_bit = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            receive_beat(req_cmd, req_line_level);
      end
   end

   // watchdog on cycles with no beat moving
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("status: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // driver: holds each beat until taken, idles at random
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (line_events.size() != 0 && (no_idle || $urandom_range(99) >= 29)) begin
            next_event = line_events.pop_front();
            req_valid <= 1'b1;
            req_cmd <= next_event.cmd;
            req_line_level <= next_event.level;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: random stalls plus a long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_served != hold_ask) begin
         hold_served <= hold_ask;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= 29);
      end
   end

   task automatic queue_beat(input logic cmd, input logic lvl);
      line_event_type ev;
      ev.cmd = cmd;
      ev.level = lvl;
      line_events.push_back(ev);
      beats_queued++;
      if (cmd == CMD_LEVEL)
         line_now = lvl;
   endtask

   // line waveform of one frame: edges where the level changes, ticks per bit
   task automatic queue_frame(input logic [7:0] data, input logic stop_lvl,
                              input int unsigned bit_len, input int slots);
      logic [9:0] bits;
      int n;
      bits = {stop_lvl, data, 1'b0};
      if (line_now == 1'b0)
         queue_beat(CMD_LEVEL, 1'b1);
      repeat ($urandom_range(3)) queue_beat(CMD_TICK, 1'($urandom_range(1)));
      for (int s = 0; s < slots; s++) begin
         // occasional repeated level on a quiet line
         if (bits[s] != line_now || $urandom_range(19) == 0)
            queue_beat(CMD_LEVEL, bits[s]);
         n = int'(bit_len);
         if ($urandom_range(7) == 0)
            n = n + int'($urandom_range(2)) - 1;
         repeat (n) queue_beat(CMD_TICK, 1'($urandom_range(1)));
      end
   endtask

   task automatic wait_drained();
      while (line_events.size() != 0 || req_valid || rx_bytes_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_timing(input logic [CNT_W-1:0] half, input logic [CNT_W-1:0] one,
                               input logic [CNT_W-1:0] one_half);
      wait_drained();
      // beats with no byte may still be in flight
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_HALF_BIT;
      csr_wdata <= half;
      @(negedge clock);
      csr_index <= CSR_ONE_BIT;
      csr_wdata <= one;
      @(negedge clock);
      csr_index <= CSR_ONE_HALF_BIT;
      csr_wdata <= one_half;
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // stimulus
   initial begin
      int unsigned bit_len;
      int unsigned half;
      int unsigned pick;
      int round;
      round = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset timing: idle tick and high level, start, early stop by edges
      queue_beat(CMD_TICK, 1'b0);
      queue_beat(CMD_LEVEL, 1'b1);
      queue_beat(CMD_LEVEL, 1'b0);
      queue_beat(CMD_TICK, 1'b1);
      queue_beat(CMD_TICK, 1'b0);
      repeat (4) begin
         queue_beat(CMD_LEVEL, 1'b1);
         queue_beat(CMD_LEVEL, 1'b0);
      end

      // one-tick timing: edges then a tick into stop, low in stop restarts
      write_timing(16'd1, 16'd1, 16'd1);
      queue_beat(CMD_LEVEL, 1'b0);
      queue_beat(CMD_TICK, 1'b1);
      repeat (3) begin
         queue_beat(CMD_LEVEL, 1'b1);
         queue_beat(CMD_LEVEL, 1'b0);
      end
      queue_beat(CMD_LEVEL, 1'b1);
      queue_beat(CMD_TICK, 1'b0);
      queue_beat(CMD_LEVEL, 1'b0);

      // random frames under changing timing
      while ((beats_queued < 1500 || bytes_checked < 48) && round < 400) begin
         if (round == 0) begin
            // zero loads wrap to a 65536 tick wait
            bit_len = 3;
            write_timing(16'd0, 16'd0, 16'd0);
         end else if (round == 1) begin
            bit_len = 3;
            write_timing(16'hffff, 16'hffff, 16'hffff);
         end else if (round == 2) begin
            bit_len = 4;
            write_timing(HALF_BIT_RST, ONE_BIT_RST, ONE_HALF_BIT_RST);
         end else begin
            bit_len = $urandom_range(1, 6);
            half = $urandom_range(1, bit_len);
            pick = $urandom_range(9);
            if (pick == 0)
               write_timing(16'd1, 16'd1, 16'd1);
            else if (pick == 1)
               write_timing(16'(half), 16'hffff, 16'(bit_len + half));
            else
               write_timing(16'(half), 16'(bit_len), 16'(bit_len + half));
         end
         no_idle = (round == 6);
         if (round == 4)
            hold_ask++;
         repeat (6) begin
            pick = $urandom_range(99);
            if (pick < 75)
               queue_frame(8'($urandom_range(255)), 1'b1, bit_len, 10);
            else if (pick < 85)
               queue_frame(8'($urandom_range(255)), 1'b0, bit_len, 10);
            else if (pick < 93)
               queue_frame(8'($urandom_range(255)), 1'($urandom_range(1)), bit_len,
                           int'($urandom_range(1, 9)));
            else
               repeat ($urandom_range(1, 8))
                  queue_beat(1'($urandom_range(1)), 1'($urandom_range(1)));
         end
         round++;
      end

      wait_drained();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
